[sv/opgs_pkg.sv]
// Shared types and constants for the operating point grid search block.
`timescale 1ns / 1ps

package opgs_pkg;

	// Default grid shape (big-core rows by little-core columns)
	localparam int DEF_ROWS = 13;
	localparam int DEF_COLS = 9;

	// Measured value width (Q8.8 throughput, Q12.4 latency)
	localparam int VAL_W  = 16;
	localparam int PROD_W = 2 * VAL_W;
	localparam int SQ_W   = 2 * PROD_W;
	localparam int COST_W = SQ_W + 1;

	// Input command codes
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_DIFF,
		S_MA,
		S_MB,
		S_SA,
		S_SB,
		S_CMP,
		S_DONE
	} state_t;

	// Step enables for the shared multiplier
	typedef struct packed {
		logic mul_a;
		logic mul_b;
		logic sq_a;
		logic sq_b;
	} cost_ctl_t;

endpackage

[sv/operating_point_grid_search.sv]
// Top level: grid store, running extremes and the query scan sequencer.
//
//  channel | dir | handshake           | fields
//  --------+-----+---------------------+----------------------------------------------------
//  in      | in  | in_valid/in_ready   | command, row_index, col_index, throughput, delay_ms
//  out     | out | out_valid/out_ready | found, best_row, best_col
//
// Clear, load and no-op transactions give no result.
// A query on a full grid runs six steps per entry (a difference step, four steps on the
// one shared multiplier and a compare step) plus accept, prep and done steps.
// A query on a partly loaded grid goes straight from accept to done with found low.
// arst_n clears the sequencer, valid bits, extremes and count; the stores are not reset.
// A result held by out_ready low stalls only the next query, not loads.
`timescale 1ns / 1ps

module operating_point_grid_search #(
	parameter int ROWS = opgs_pkg::DEF_ROWS,
	parameter int COLS = opgs_pkg::DEF_COLS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [3:0]  row_index,
	input  logic [3:0]  col_index,
	input  logic [15:0] throughput,
	input  logic [15:0] delay_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [3:0]  best_row,
	output logic [3:0]  best_col
);

	localparam int VW   = opgs_pkg::VAL_W;
	localparam int CSTW = opgs_pkg::COST_W;
	localparam int GRID = ROWS * COLS;
	localparam int AW   = (GRID > 1) ? $clog2(GRID) : 1;
	localparam int CW   = $clog2(GRID + 1);
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int KW   = (COLS > 1) ? $clog2(COLS) : 1;

	opgs_pkg::state_t  state_q, state_d;
	opgs_pkg::cost_ctl_t cost_ctl;

	// Grid stores and per-entry written flags
	logic [VW-1:0]   rate_mem  [GRID];
	logic [VW-1:0]   delay_mem [GRID];
	logic [GRID-1:0] written_q;
	logic [CW-1:0]   count_q;

	logic [VW-1:0] rate_low_q, rate_high_q, delay_low_q, delay_high_q;
	logic [VW-1:0] rd_rate_q, rd_delay_q;
	logic [VW-1:0] tgt_rate_q, tgt_delay_q;
	logic [VW-1:0] rate_rng_q, delay_rng_q;
	logic [VW-1:0] sf_q, ex_q;
	logic [AW-1:0] addr_q;
	logic [RW-1:0] cur_row_q, best_r_q;
	logic [KW-1:0] cur_col_q, best_c_q;
	logic [CSTW-1:0] best_cost_q;
	logic [CSTW-1:0] cost;
	logic          first_q;
	logic          res_found_q;

	logic          out_valid_q, found_q;
	logic [3:0]    out_row_q, out_col_q;

	logic          accept;
	logic          ld_ok;
	logic [AW-1:0] ld_addr;
	logic          grid_full;
	logic          last_entry;
	logic          take;
	logic          out_free;
	logic [VW-1:0] clamp_rate, clamp_delay;

	assign accept    = in_valid && in_ready;
	assign ld_ok     = ({1'b0, row_index} < 5'(ROWS)) && ({1'b0, col_index} < 5'(COLS));
	assign ld_addr   = AW'(32'(row_index) * COLS + 32'(col_index));
	assign grid_full = (count_q == CW'(GRID));
	assign last_entry = (cur_row_q == RW'(ROWS - 1)) && (cur_col_q == KW'(COLS - 1));
	assign take      = first_q || (cost < best_cost_q);
	assign out_free  = !out_valid_q || out_ready;

	// Target clamped into the observed range
	always_comb begin
		clamp_rate = throughput;
		if (clamp_rate < rate_low_q)  clamp_rate = rate_low_q;
		if (clamp_rate > rate_high_q) clamp_rate = rate_high_q;
		clamp_delay = delay_ms;
		if (clamp_delay < delay_low_q)  clamp_delay = delay_low_q;
		if (clamp_delay > delay_high_q) clamp_delay = delay_high_q;
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= opgs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, ready and multiplier steps
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cost_ctl = '0;
		unique case (state_q)
			opgs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && (opgs_pkg::cmd_t'(command) == opgs_pkg::CMD_QUERY)) begin
					state_d = grid_full ? opgs_pkg::S_PREP : opgs_pkg::S_DONE;
				end
			end
			opgs_pkg::S_PREP: state_d = opgs_pkg::S_DIFF;
			opgs_pkg::S_DIFF: state_d = opgs_pkg::S_MA;
			opgs_pkg::S_MA: begin
				cost_ctl.mul_a = 1'b1;
				state_d = opgs_pkg::S_MB;
			end
			opgs_pkg::S_MB: begin
				cost_ctl.mul_b = 1'b1;
				state_d = opgs_pkg::S_SA;
			end
			opgs_pkg::S_SA: begin
				cost_ctl.sq_a = 1'b1;
				state_d = opgs_pkg::S_SB;
			end
			opgs_pkg::S_SB: begin
				cost_ctl.sq_b = 1'b1;
				state_d = opgs_pkg::S_CMP;
			end
			opgs_pkg::S_CMP: state_d = last_entry ? opgs_pkg::S_DONE : opgs_pkg::S_DIFF;
			opgs_pkg::S_DONE: begin
				if (out_free) state_d = opgs_pkg::S_IDLE;
			end
			default: state_d = opgs_pkg::S_IDLE;
		endcase
	end

	// Store write and registered scan read
	always_ff @(posedge clk) begin
		if (accept && (opgs_pkg::cmd_t'(command) == opgs_pkg::CMD_LOAD) && ld_ok) begin
			rate_mem[ld_addr]  <= throughput;
			delay_mem[ld_addr] <= delay_ms;
		end
		rd_rate_q  <= rate_mem[addr_q];
		rd_delay_q <= delay_mem[addr_q];
	end

	// Written flags, count and running extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			count_q      <= '0;
			rate_low_q   <= '1;
			rate_high_q  <= '0;
			delay_low_q  <= '1;
			delay_high_q <= '0;
		end else if (accept) begin
			case (opgs_pkg::cmd_t'(command))
				opgs_pkg::CMD_CLEAR: begin
					written_q    <= '0;
					count_q      <= '0;
					rate_low_q   <= '1;
					rate_high_q  <= '0;
					delay_low_q  <= '1;
					delay_high_q <= '0;
				end
				opgs_pkg::CMD_LOAD: begin
					if (ld_ok) begin
						written_q[ld_addr] <= 1'b1;
						if (!written_q[ld_addr]) count_q <= count_q + 1'b1;
						if (throughput < rate_low_q)  rate_low_q   <= throughput;
						if (throughput > rate_high_q) rate_high_q  <= throughput;
						if (delay_ms < delay_low_q)   delay_low_q  <= delay_ms;
						if (delay_ms > delay_high_q)  delay_high_q <= delay_ms;
					end
				end
				default: ;
			endcase
		end
	end

	// Scan datapath
	always_ff @(posedge clk) begin
		case (state_q)
			opgs_pkg::S_IDLE: begin
				addr_q      <= '0;
				cur_row_q   <= '0;
				cur_col_q   <= '0;
				first_q     <= 1'b1;
				best_r_q    <= '0;
				best_c_q    <= '0;
				res_found_q <= 1'b0;
				tgt_rate_q  <= clamp_rate;
				tgt_delay_q <= clamp_delay;
				rate_rng_q  <= rate_high_q - rate_low_q;
				delay_rng_q <= delay_high_q - delay_low_q;
			end
			opgs_pkg::S_DIFF: begin
				sf_q   <= (tgt_rate_q > rd_rate_q) ? (tgt_rate_q - rd_rate_q) : '0;
				ex_q   <= (rd_delay_q > tgt_delay_q) ? (rd_delay_q - tgt_delay_q) : '0;
				addr_q <= addr_q + 1'b1;
			end
			opgs_pkg::S_CMP: begin
				first_q <= 1'b0;
				if (take) begin
					best_cost_q <= cost;
					best_r_q    <= cur_row_q;
					best_c_q    <= cur_col_q;
				end
				if (cur_col_q == KW'(COLS - 1)) begin
					cur_col_q <= '0;
					cur_row_q <= cur_row_q + 1'b1;
				end else begin
					cur_col_q <= cur_col_q + 1'b1;
				end
				if (last_entry) res_found_q <= 1'b1;
			end
			default: ;
		endcase
	end

	opgs_cost_unit u_cost (
		.clk         (clk),
		.ctl         (cost_ctl),
		.shortfall   (sf_q),
		.excess      (ex_q),
		.rate_range  (rate_rng_q),
		.delay_range (delay_rng_q),
		.cost        (cost)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
		end else if ((state_q == opgs_pkg::S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
			found_q     <= res_found_q;
			out_row_q   <= res_found_q ? 4'(best_r_q) : 4'd0;
			out_col_q   <= res_found_q ? 4'(best_c_q) : 4'd0;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign best_row  = out_row_q;
	assign best_col  = out_col_q;

endmodule

[sv/opgs_cost_unit.sv]
// Shared 32x32 multiplier that builds one entry's cost over four steps.
`timescale 1ns / 1ps

module opgs_cost_unit (
	input  logic                                clk,
	input  opgs_pkg::cost_ctl_t                 ctl,
	input  logic [opgs_pkg::VAL_W-1:0]          shortfall,
	input  logic [opgs_pkg::VAL_W-1:0]          excess,
	input  logic [opgs_pkg::VAL_W-1:0]          rate_range,
	input  logic [opgs_pkg::VAL_W-1:0]          delay_range,
	output logic [opgs_pkg::COST_W-1:0]         cost
);

	localparam int VW = opgs_pkg::VAL_W;
	localparam int PW = opgs_pkg::PROD_W;
	localparam int SW = opgs_pkg::SQ_W;

	logic [PW-1:0] op_x;
	logic [PW-1:0] op_y;
	logic [SW-1:0] prod;
	logic [PW-1:0] a_q;
	logic [PW-1:0] b_q;
	logic [SW-1:0] sqa_q;
	logic [SW-1:0] sqb_q;

	// Operand select: scaled shortfall, scaled excess, then their squares
	always_comb begin
		op_x = '0;
		op_y = '0;
		if (ctl.mul_a) begin
			op_x = {{(PW-VW){1'b0}}, shortfall};
			op_y = {{(PW-VW){1'b0}}, delay_range};
		end else if (ctl.mul_b) begin
			op_x = {{(PW-VW){1'b0}}, excess};
			op_y = {{(PW-VW){1'b0}}, rate_range};
		end else if (ctl.sq_a) begin
			op_x = a_q;
			op_y = a_q;
		end else if (ctl.sq_b) begin
			op_x = b_q;
			op_y = b_q;
		end
	end

	assign prod = op_x * op_y;

	// Step results
	always_ff @(posedge clk) begin
		if (ctl.mul_a) a_q <= prod[PW-1:0];
		if (ctl.mul_b) b_q <= prod[PW-1:0];
		if (ctl.sq_a)  sqa_q <= prod;
		if (ctl.sq_b)  sqb_q <= prod;
	end

	// 65-bit sum, carry kept
	assign cost = {1'b0, sqa_q} + {1'b0, sqb_q};

endmodule

[sv/opgs_checker.sv]
// Port-level checks for the operating point grid search, bound to the top level.
`timescale 1ns / 1ps

module opgs_checker #(
	parameter int ROWS = opgs_pkg::DEF_ROWS,
	parameter int COLS = opgs_pkg::DEF_COLS
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  command,
	input logic        out_valid,
	input logic        out_ready,
	input logic        found,
	input logic [3:0]  best_row,
	input logic [3:0]  best_col
);

	// A held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found)
			&& $stable(best_row) && $stable(best_col))
		else $error("result changed while stalled");

	// A miss reports row and column zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> best_row == 4'd0 && best_col == 4'd0)
		else $error("miss with nonzero index");

	// A hit lies inside the grid
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> {1'b0, best_row} < 5'(ROWS) && {1'b0, best_col} < 5'(COLS))
		else $error("hit outside grid");

	// A query transaction makes the block busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == opgs_pkg::CMD_QUERY |=> !in_ready)
		else $error("ready right after query");

endmodule

bind operating_point_grid_search opgs_checker #(.ROWS(ROWS), .COLS(COLS)) u_opgs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.command   (command),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.found     (found),
	.best_row  (best_row),
	.best_col  (best_col)
);
